// ===== rtl/mps_pkg.sv =====
// shared constants and types for the max product subarray block
`default_nettype none

package mps_pkg;

   localparam int SAMPLE_WIDTH_DEF  = 8;
   localparam int PRODUCT_WIDTH_DEF = 32;
   localparam int QUEUE_DEPTH_DEF   = 4;
   localparam int RESULT_WIDTH      = 32;

   typedef struct packed {
      logic last;
      logic is_zero;
      logic is_neg;
   } item_class_type;

endpackage

`default_nettype wire

// ===== rtl/mps_front.sv =====
// input side: sample classification and the item queue toward the back end
`default_nettype none

module mps_front #(
   parameter int SAMPLE_WIDTH = mps_pkg::SAMPLE_WIDTH_DEF,
   parameter int QUEUE_DEPTH  = mps_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  signed [SAMPLE_WIDTH-1:0]  req_sample,
   input  wire                             req_last,
   output logic                            q_valid,
   input  wire                             q_pop,
   output logic signed [SAMPLE_WIDTH-1:0]  q_sample,
   output mps_pkg::item_class_type         q_class
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic signed [SAMPLE_WIDTH-1:0] sample_mem [QUEUE_DEPTH];
   mps_pkg::item_class_type        class_mem  [QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   mps_pkg::item_class_type in_class;
   logic push;
   logic pop;

   always_comb begin
      in_class.last    = req_last;
      in_class.is_zero = (req_sample == '0);
      in_class.is_neg  = req_sample[SAMPLE_WIDTH-1];
   end

   assign req_ready = (count_ff != CNT_FULL);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_sample  = sample_mem[rd_ptr_ff];
   assign q_class   = class_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         sample_mem[wr_ptr_ff] <= req_sample;
         class_mem[wr_ptr_ff]  <= in_class;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mps_back.sv =====
// execution side: running products, best product and the result register
`default_nettype none

module mps_back #(
   parameter int SAMPLE_WIDTH  = mps_pkg::SAMPLE_WIDTH_DEF,
   parameter int PRODUCT_WIDTH = mps_pkg::PRODUCT_WIDTH_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    q_valid,
   output logic                                   q_pop,
   input  wire  signed [SAMPLE_WIDTH-1:0]         q_sample,
   input  mps_pkg::item_class_type                q_class,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic        [mps_pkg::RESULT_WIDTH-1:0] rsp_max_product
);

   localparam int RW = mps_pkg::RESULT_WIDTH;
   localparam int PW = PRODUCT_WIDTH;
   localparam int VW = (PRODUCT_WIDTH > SAMPLE_WIDTH) ? PRODUCT_WIDTH : SAMPLE_WIDTH;
   localparam int MW = VW + SAMPLE_WIDTH;
   localparam logic signed [VW-1:0] PROD_MAX = VW'({1'b0, {(PW-1){1'b1}}});
   localparam logic signed [VW-1:0] PROD_MIN = -PROD_MAX - VW'(1);

   function automatic logic signed [VW-1:0] sat_mul(
      input logic signed [VW-1:0]           a,
      input logic signed [SAMPLE_WIDTH-1:0] b
   );
      logic signed [MW-1:0] full;
      logic signed [VW-1:0] res;
      full = MW'(a) * MW'(b);
      if (full > MW'(PROD_MAX)) begin
         res = PROD_MAX;
      end else if (full < MW'(PROD_MIN)) begin
         res = PROD_MIN;
      end else begin
         res = VW'(full);
      end
      return res;
   endfunction

   // running state
   logic                 pos_valid_ff, pos_valid_in;
   logic signed [VW-1:0] pos_ff, pos_in;
   logic                 neg_valid_ff, neg_valid_in;
   logic signed [VW-1:0] neg_ff, neg_in;
   logic                 zero_seen_ff, zero_seen_in;
   logic signed [VW-1:0] best_ff, best_in;

   // compare stage
   logic                 stg_valid_ff, stg_valid_in;
   logic signed [VW-1:0] stg_c1_ff, stg_c1_in;
   logic                 stg_c1v_ff, stg_c1v_in;
   logic signed [VW-1:0] stg_c2_ff, stg_c2_in;
   logic                 stg_c2v_ff, stg_c2v_in;
   logic                 stg_last_ff, stg_last_in;
   logic                 stg_zs_ff, stg_zs_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic [RW-1:0]        out_ff, out_in;

   logic                    advance;
   logic signed [VW-1:0]    x_ext;
   logic signed [VW-1:0]    mul_pos;
   logic signed [VW-1:0]    mul_neg;
   logic signed [VW-1:0]    cand_a;
   logic signed [VW-1:0]    best_1;
   logic signed [VW-1:0]    best_2;
   logic signed [VW-1:0]    final_v;
   logic signed [VW+RW-1:0] final_wide;

   assign advance = !out_valid_ff || rsp_ready;
   assign q_pop   = advance && q_valid;
   assign x_ext   = VW'(q_sample);
   assign mul_pos = sat_mul(pos_ff, q_sample);
   assign mul_neg = sat_mul(neg_ff, q_sample);
   assign cand_a  = pos_valid_ff ? mul_pos : x_ext;

   // state update for the popped item
   always_comb begin
      pos_valid_in = pos_valid_ff;
      pos_in       = pos_ff;
      neg_valid_in = neg_valid_ff;
      neg_in       = neg_ff;
      zero_seen_in = zero_seen_ff;
      stg_valid_in = stg_valid_ff;
      stg_c1_in    = stg_c1_ff;
      stg_c1v_in   = stg_c1v_ff;
      stg_c2_in    = stg_c2_ff;
      stg_c2v_in   = stg_c2v_ff;
      stg_last_in  = stg_last_ff;
      stg_zs_in    = stg_zs_ff;
      if (advance) begin
         stg_valid_in = q_pop;
         stg_c1_in    = cand_a;
         stg_c1v_in   = !q_class.is_zero;
         stg_c2_in    = mul_neg;
         stg_c2v_in   = !q_class.is_zero && neg_valid_ff;
         stg_last_in  = q_class.last;
         stg_zs_in    = zero_seen_ff || q_class.is_zero;
      end
      if (q_pop) begin
         priority if (q_class.is_zero) begin
            pos_valid_in = 1'b0;
            neg_valid_in = 1'b0;
            zero_seen_in = 1'b1;
         end else if (q_class.is_neg) begin
            neg_valid_in = 1'b1;
            neg_in       = cand_a;
            pos_valid_in = neg_valid_ff;
            pos_in       = mul_neg;
         end else begin
            pos_valid_in = 1'b1;
            pos_in       = cand_a;
            neg_in       = mul_neg;
         end
         if (q_class.last) begin
            pos_valid_in = 1'b0;
            neg_valid_in = 1'b0;
            zero_seen_in = 1'b0;
         end
      end
   end

   // best product and result
   always_comb begin
      best_1     = (stg_c1v_ff && (stg_c1_ff > best_ff)) ? stg_c1_ff : best_ff;
      best_2     = (stg_c2v_ff && (stg_c2_ff > best_1)) ? stg_c2_ff : best_1;
      final_v    = (stg_zs_ff && (best_2 < 0)) ? '0 : best_2;
      final_wide = (VW+RW)'(final_v);
      best_in      = best_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = stg_valid_ff && stg_last_ff;
         if (stg_valid_ff) begin
            best_in = stg_last_ff ? PROD_MIN : best_2;
            out_in  = final_wide[RW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_valid_ff <= 1'b0;
         neg_valid_ff <= 1'b0;
         zero_seen_ff <= 1'b0;
         best_ff      <= PROD_MIN;
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_valid_ff <= pos_valid_in;
         neg_valid_ff <= neg_valid_in;
         zero_seen_ff <= zero_seen_in;
         best_ff      <= best_in;
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      neg_ff      <= neg_in;
      stg_c1_ff   <= stg_c1_in;
      stg_c1v_ff  <= stg_c1v_in;
      stg_c2_ff   <= stg_c2_in;
      stg_c2v_ff  <= stg_c2v_in;
      stg_last_ff <= stg_last_in;
      stg_zs_ff   <= stg_zs_in;
      out_ff      <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_max_product = out_ff;

endmodule

`default_nettype wire

// ===== rtl/max_product_subarray_core.sv =====
// top level of the streaming maximum product subarray block
//
// usage:
//  - req channel carries one signed sample per transfer, tlast marks the final
//    sample of a sequence
//  - rsp channel carries one transfer per sequence: the largest product of any
//    contiguous run, saturated at the signed product limits, floored at zero
//    when the sequence held a zero
//  - throughput: one sample per cycle while no result stalls on rsp_tready, set
//    by the saturating multiply and state update in the back end
//  - result path: the final sample passes the queue, then the pop with
//    state update, then the best-product compare that loads rsp_tvalid
//  - a four-entry queue sits between the input side and the back end; while a
//    result waits on rsp_tready low the back end holds and the queue keeps
//    taking samples until it fills, then req_tready drops
//  - reset clears the queue, running products, best product and the result
//    register; the block is ready in the cycle after reset is released
`default_nettype none

module max_product_subarray_core #(
   parameter int SAMPLE_WIDTH  = mps_pkg::SAMPLE_WIDTH_DEF,
   parameter int PRODUCT_WIDTH = mps_pkg::PRODUCT_WIDTH_DEF,
   parameter int QUEUE_DEPTH   = mps_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]   req_tdata,  // sample
   input  wire                                 req_tlast,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [mps_pkg::RESULT_WIDTH-1:0]    rsp_tdata   // max_product
);

   logic signed [SAMPLE_WIDTH-1:0] req_sample;
   logic                           q_valid;
   logic                           q_pop;
   logic signed [SAMPLE_WIDTH-1:0] q_sample;
   mps_pkg::item_class_type        q_class;

   assign req_sample = req_tdata[SAMPLE_WIDTH-1:0];

   mps_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .QUEUE_DEPTH  (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_sample (req_sample),
      .req_last   (req_tlast),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_sample   (q_sample),
      .q_class    (q_class)
   );

   mps_back #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .PRODUCT_WIDTH (PRODUCT_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_sample        (q_sample),
      .q_class         (q_class),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_max_product (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_pop_needs_item : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !q_pop)
      else $error("back end advanced while the result was stalled");

   a_push_fills_queue : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> q_valid)
      else $error("accepted sample missing from the queue");
`endif

endmodule

`default_nettype wire
